// ----- hw/rtl/bdc_pkg.sv -----
// Shared types and constants for the block dominant color unit.
package bdc_pkg;

  localparam int unsigned MaxColorsDef = 256;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned ColorW       = 3 * ChanW;
  localparam int unsigned ModeCountW   = 16;
  localparam int unsigned QueueDepth   = 4;

  // One pixel as it travels from the front queue to the counting engine.
  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              last;
  } pix_t;

  // Pixel queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hw/rtl/block_dominant_color.sv -----
// Per pixel: the engine dequeues it, then reads the stored colors one by one until it finds a match or
// reaches the fill count; the single read port of the color table sets this pace.
// A four-word input queue keeps accepting while the engine scans, until the queue is full.
// Result: loaded in the emit state after the last pixel is counted, and held in an output register until taken.
// Reset (rst_ni low, asynchronous): queue empty, table empty, best color and flags zero;
// the table RAM needs no clearing pass since only entries below the fill count are read.
module block_dominant_color #(
  parameter int unsigned MAX_COLORS = bdc_pkg::MaxColorsDef,
  parameter int unsigned COUNT_BITS = bdc_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tlast,  // last pixel of the block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // mode_red [7:0], mode_green [15:8], mode_blue [23:16],
                                     // mode_count [39:24], table_overflow [40], zero [47:41]
);
  import bdc_pkg::*;

  pix_t                  pix;
  logic                  pix_valid, pix_ready;
  q_stat_t               q_stat;
  logic [ColorW-1:0]     mode_color;
  logic [ModeCountW-1:0] mode_count;
  logic                  overflow;

  bdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .pix_o       (pix),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .stat_o      (q_stat)
  );

  bdc_back #(
    .MAX_COLORS (MAX_COLORS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix),
    .pix_valid_i  (pix_valid),
    .pix_ready_o  (pix_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .mode_color_o (mode_color),
    .mode_count_o (mode_count),
    .overflow_o   (overflow)
  );

  // Unpack red from the top byte of the packed color.
  assign m_axis_tdata = {7'd0, overflow, mode_count, mode_color[ChanW-1:0],
                         mode_color[2*ChanW-1:ChanW], mode_color[3*ChanW-1:2*ChanW]};

`ifndef SYNTHESIS
  // A result never carries a zero count.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:24] != 16'd0))
    else $error("result with zero count");

  // The engine never sees a word from an empty queue.
  a_empty_no_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !pix_valid)
    else $error("queue empty but pixel offered");

  // Backpressure on the input comes only from a full queue.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_stat.full)
    else $error("input stalled with room in queue");
`endif

endmodule

// ----- hw/rtl/bdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bdc_front.sv -----
// Front end: accepts pixel words, packs the color and queues them for the engine.
module bdc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bdc_pkg::ColorW-1:0]      in_data_i,
  input  logic                            in_last_i,
  output bdc_pkg::pix_t                   pix_o,
  output logic                            pix_valid_o,
  input  logic                            pix_ready_i,
  output bdc_pkg::q_stat_t                stat_o
);
  import bdc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  pix_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  pix_t            in_pix;
  logic            push, pop;

  // Pack as red in the top byte, blue in the bottom byte.
  assign in_pix.color = {in_data_i[ChanW-1:0], in_data_i[2*ChanW-1:ChanW],
                         in_data_i[3*ChanW-1:2*ChanW]};
  assign in_pix.last  = in_last_i;

  assign stat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);

  assign in_ready_o  = !stat_o.full;
  assign pix_valid_o = !stat_o.empty;
  assign pix_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = pix_valid_o && pix_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_pix;
    end
  end

endmodule

// ----- hw/rtl/bdc_back.sv -----
// Back end: scans the color table, updates counts, tracks the best color, holds the result.
module bdc_back #(
  parameter int unsigned MAX_COLORS = bdc_pkg::MaxColorsDef,
  parameter int unsigned COUNT_BITS = bdc_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bdc_pkg::pix_t                   pix_i,
  input  logic                            pix_valid_i,
  output logic                            pix_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bdc_pkg::ColorW-1:0]      mode_color_o,
  output logic [bdc_pkg::ModeCountW-1:0]  mode_count_o,
  output logic                            overflow_o
);
  import bdc_pkg::*;

  localparam int unsigned AddrW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned UsedW = $clog2(MAX_COLORS + 1);
  localparam int unsigned EntW  = ColorW + COUNT_BITS;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [1:0]            state_q, state_d;
  pix_t                  cur_q;
  logic [UsedW-1:0]      scan_q, scan_d;
  logic                  pend_q, pend_d;
  logic [AddrW-1:0]      rd_addr_q;
  logic [UsedW-1:0]      used_q, used_d;
  logic [ColorW-1:0]     best_color_q, best_color_d;
  logic [COUNT_BITS-1:0] best_count_q, best_count_d;
  logic                  ovf_q, ovf_d;
  logic                  out_valid_q, out_valid_d;
  logic [ColorW-1:0]     out_color_q;
  logic [ModeCountW-1:0] out_count_q;
  logic                  out_ovf_q;

  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_waddr;
  logic [EntW-1:0]       ram_wdata, ram_rdata;
  logic [ColorW-1:0]     ent_color;
  logic [COUNT_BITS-1:0] ent_count, inc_count, cand_count;
  logic                  in_scan, hit, miss, insert, take, load_out;
  logic [ModeCountW-1:0] mode_cnt;

  bdc_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_COLORS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent_color = ram_rdata[EntW-1:COUNT_BITS];
  assign ent_count = ram_rdata[COUNT_BITS-1:0];
  assign inc_count = (ent_count == CountMax) ? ent_count : ent_count + 1'b1;

  assign in_scan = (state_q == StScan);
  assign hit     = in_scan && pend_q && (ent_color == cur_q.color);
  // No read in flight and every stored entry checked: the color is new.
  assign miss    = in_scan && !pend_q && (scan_q == used_q);
  assign insert  = miss && (used_q != UsedW'(MAX_COLORS));
  assign ram_re  = in_scan && !hit && (scan_q != used_q);

  assign ram_we    = hit || insert;
  assign ram_waddr = hit ? rd_addr_q : used_q[AddrW-1:0];
  assign cand_count = hit ? inc_count : COUNT_BITS'(1);
  assign ram_wdata = {cur_q.color, cand_count};

  // Higher count wins; equal counts go to the smaller packed color.
  assign take = ram_we && ((cand_count > best_count_q) ||
                           ((cand_count == best_count_q) && (cur_q.color < best_color_q)));

  assign load_out = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  generate
    if (COUNT_BITS > ModeCountW) begin : g_sat
      assign mode_cnt = (|best_count_q[COUNT_BITS-1:ModeCountW]) ? {ModeCountW{1'b1}}
                                                                  : best_count_q[ModeCountW-1:0];
    end else begin : g_ext
      assign mode_cnt = ModeCountW'(best_count_q);
    end
  endgenerate

  assign pix_ready_o = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    pend_d       = ram_re;
    used_d       = used_q;
    best_color_d = best_color_q;
    best_count_d = best_count_q;
    ovf_d        = ovf_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (ram_re) begin
      scan_d = scan_q + 1'b1;
    end
    if (take) begin
      best_color_d = cur_q.color;
      best_count_d = cand_count;
    end
    if (insert) begin
      used_d = used_q + 1'b1;
    end
    if (miss && !insert) begin
      ovf_d = 1'b1;
    end
    case (state_q)
      StIdle: begin
        scan_d = '0;
        if (pix_valid_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (hit || miss) begin
          state_d = cur_q.last ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (load_out) begin
          out_valid_d  = 1'b1;
          used_d       = '0;
          best_color_d = '0;
          best_count_d = '0;
          ovf_d        = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      scan_q       <= '0;
      pend_q       <= 1'b0;
      used_q       <= '0;
      best_color_q <= '0;
      best_count_q <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      pend_q       <= pend_d;
      used_q       <= used_d;
      best_color_q <= best_color_d;
      best_count_q <= best_count_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      cur_q <= pix_i;
    end
    if (ram_re) begin
      rd_addr_q <= scan_q[AddrW-1:0];
    end
    if (load_out) begin
      out_color_q <= best_color_q;
      out_count_q <= mode_cnt;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mode_color_o = out_color_q;
  assign mode_count_o = out_count_q;
  assign overflow_o   = out_ovf_q;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for block_dominant_color: pixel blocks in, predicted mode colors out.
module tb_top;
  import bdc_pkg::*;

  localparam longint unsigned CountMax   = (64'd1 << CountBitsDef) - 1;
  localparam longint unsigned CycleLimit = 3_000_000;
  localparam int unsigned     DrainWait  = 2000;

  typedef struct packed {
    logic [ChanW-1:0]      red;
    logic [ChanW-1:0]      green;
    logic [ChanW-1:0]      blue;
    logic [ModeCountW-1:0] count;
    logic                  overflow;
  } mode_t;

  class mode_scoreboard;
    logic [ColorW-1:0] color_tab [MaxColorsDef];
    longint unsigned   count_tab [MaxColorsDef];
    int unsigned       fill;
    logic [ColorW-1:0] best_color;
    longint unsigned   best_count;
    bit                overflow_seen;
    mode_t             expected_modes [$];
    int unsigned       mismatch_count;

    function new();
      fill           = 0;
      best_color     = '0;
      best_count     = 0;
      overflow_seen  = 1'b0;
      mismatch_count = 0;
    endfunction

    function void offer_best(logic [ColorW-1:0] color, longint unsigned count);
      if (count > best_count || (count == best_count && color < best_color)) begin
        best_count = count;
        best_color = color;
      end
    endfunction

    // Count one accepted pixel; color is packed red, green, blue from the top down.
    function void note_pixel(logic [ColorW-1:0] color, logic last);
      bit    hit;
      mode_t mode;
      hit = 1'b0;
      for (int unsigned k = 0; k < fill && !hit; k++) begin
        if (color_tab[k] == color) begin
          if (count_tab[k] < CountMax) count_tab[k]++;
          offer_best(color, count_tab[k]);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (fill < MaxColorsDef) begin
          color_tab[fill] = color;
          count_tab[fill] = 1;
          fill++;
          offer_best(color, 1);
        end else begin
          overflow_seen = 1'b1;
        end
      end
      if (last) begin
        mode.red      = best_color[23:16];
        mode.green    = best_color[15:8];
        mode.blue     = best_color[7:0];
        mode.count    = (best_count > 64'hFFFF) ? 16'hFFFF : best_count[ModeCountW-1:0];
        mode.overflow = overflow_seen;
        expected_modes.push_back(mode);
        fill          = 0;
        best_color    = '0;
        best_count    = 0;
        overflow_seen = 1'b0;
      end
    endfunction

    function void check_mode(logic [47:0] word);
      mode_t want;
      if (expected_modes.size() == 0) begin
        $error("result word %h with no block pending", word);
        mismatch_count++;
        return;
      end
      want = expected_modes.pop_front();
      if (word[7:0] !== want.red) begin
        $error("mode_red: expected %0d, got %0d", want.red, word[7:0]);
        mismatch_count++;
      end
      if (word[15:8] !== want.green) begin
        $error("mode_green: expected %0d, got %0d", want.green, word[15:8]);
        mismatch_count++;
      end
      if (word[23:16] !== want.blue) begin
        $error("mode_blue: expected %0d, got %0d", want.blue, word[23:16]);
        mismatch_count++;
      end
      if (word[39:24] !== want.count) begin
        $error("mode_count: expected %0d, got %0d", want.count, word[39:24]);
        mismatch_count++;
      end
      if (word[40] !== want.overflow) begin
        $error("table_overflow: expected %0d, got %0d", want.overflow, word[40]);
        mismatch_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_modes.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  mode_scoreboard  sb = new();
  int unsigned     send_idle_pct = 12;
  int unsigned     recv_idle_pct = 60;
  longint unsigned cycle_count   = 0;

  block_dominant_color i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_mode(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Enter and leave at a falling edge; tvalid stays up so back-to-back words need no toggle.
  task automatic send_pixel(input logic [ColorW-1:0] rgb, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(rgb, last);
    @(negedge clk_i);
  endtask

  // Hold the sender until every block result has been taken.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [ColorW-1:0] table_color(int unsigned k);
    logic [7:0] b;
    b = k[7:0];
    return {b, ~b, b ^ 8'h5A} ^ {15'd0, k[8], 8'd0};
  endfunction

  task automatic run_directed();
    logic [ColorW-1:0] hi_color;
    logic [ColorW-1:0] lo_color;
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b1);
    // Tie: the smaller packed color wins whichever reaches the count first.
    hi_color = 24'h804020;
    lo_color = 24'h102030;
    send_pixel(hi_color, 1'b0);
    send_pixel(lo_color, 1'b0);
    send_pixel(hi_color, 1'b0);
    send_pixel(lo_color, 1'b1);
    send_pixel(lo_color, 1'b0);
    send_pixel(hi_color, 1'b0);
    send_pixel(lo_color, 1'b0);
    send_pixel(hi_color, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h000001, 1'b1);
    // Repeat one color many times, then end on a different color.
    for (int unsigned k = 0; k < 40; k++) send_pixel(24'h55AA33, 1'b0);
    send_pixel(24'h010203, 1'b1);
    // Fill the table exactly: no drop.
    for (int unsigned k = 0; k < MaxColorsDef; k++) begin
      send_pixel(table_color(k), k == MaxColorsDef - 1);
    end
    // Fill, drop two new colors, keep counting stored ones, end on a dropped color.
    for (int unsigned k = 0; k < MaxColorsDef; k++) send_pixel(table_color(k), 1'b0);
    send_pixel(24'hFEDCBA, 1'b0);
    send_pixel(24'h123456, 1'b0);
    send_pixel(table_color(200), 1'b0);
    send_pixel(table_color(200), 1'b0);
    send_pixel(table_color(7), 1'b0);
    send_pixel(24'hABCDEF, 1'b1);
    // Flag and table must be clear again.
    send_pixel(24'hFEDCBA, 1'b1);
  endtask

  task automatic run_random_blocks(input int unsigned item_goal, input bit wide_first);
    int unsigned       sent;
    int unsigned       len;
    int unsigned       kind;
    int unsigned       pal_n;
    logic [ColorW-1:0] palette [4];
    logic [ColorW-1:0] color;
    sent = 0;
    // One wide block to push the table past full.
    if (wide_first) begin
      for (int p = 0; p < 4; p++) palette[p] = ColorW'($urandom());
      len = $urandom_range(380, 340);
      for (int unsigned k = 0; k < len; k++) begin
        color = ($urandom_range(4) == 0) ? palette[$urandom_range(3)] : ColorW'($urandom());
        send_pixel(color, k == len - 1);
      end
      sent += len;
    end
    while (sent < item_goal) begin
      kind  = $urandom_range(9);
      pal_n = $urandom_range(4, 1);
      for (int p = 0; p < 4; p++) begin
        palette[p] = ColorW'($urandom());
        // Near-equal colors make the tie order depend on low bits.
        if (kind == 0 && p > 0) palette[p] = palette[0] ^ ColorW'($urandom_range(3));
      end
      len = (kind < 8) ? $urandom_range(16, 1) : $urandom_range(6, 1);
      for (int unsigned k = 0; k < len; k++) begin
        color = (kind < 8) ? palette[$urandom_range(pal_n - 1)] : ColorW'($urandom());
        send_pixel(color, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 60;
    run_directed();
    wait_results_drained();
    run_random_blocks(480, 1'b1);

    send_idle_pct = 60;
    recv_idle_pct = 12;
    run_random_blocks(200, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_blocks(200, 1'b0);

    wait_results_drained();
    repeat (DrainWait) @(negedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
